// ----- rtl/bounded_deque_with_search_defines.svh -----
// ----------------------------------------------------------------------------
// Deque assertion macros
// Shared concurrent assertion forms for the deque checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH

// Assert a property on a given clock, skipped while reset is low.
`define BDQ_ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the block clock and reset.
`define BDQ_ASSERT(label, prop, msg) \
    `BDQ_ASSERT_AT(label, i_clk, i_rst_n, prop, msg)

`endif

// ----- rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// Deque package
// Operation codes, status codes, FSM states and field widths of the deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int KIND_W    = 3;
    localparam int FIELD_W   = 16;
    localparam int OCC_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 2 * FIELD_W;
    localparam int M_PAD_W   = 6;
    localparam int M_TDATA_W = 2 * FIELD_W + 1 + STATUS_W + OCC_W + M_PAD_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_PEEK_FRONT = 3'd4,
        KIND_PEEK_BACK  = 3'd5,
        KIND_SEARCH     = 3'd6,
        KIND_CLEAR      = 3'd7
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_SCAN = 2'd2,
        S_DONE = 2'd3
    } t_state;

    typedef struct packed {
        logic [OCC_W-1:0]   occupancy;
        t_status            status;
        logic               found;
        logic [FIELD_W-1:0] out_row;
        logic [FIELD_W-1:0] out_col;
        logic               out_valid;
    } t_result;

endpackage

// ----- rtl/bounded_deque_with_search.sv -----
// ----------------------------------------------------------------------------
// Bounded deque with search
// Double-ended queue of (column, row) coordinates in a ring memory.
// ----------------------------------------------------------------------------
// One operation per input transfer (push/pop/peek at either end, search,
// clear), one result transfer per operation. Entries live in a single-port
// write / single-port read ring memory of DEPTH words with a registered read
// port; front and back indices and the entry count sit in flip-flops.
// Operations run one at a time. A push, a clear, a refused push and a pop,
// peek or search on an empty queue go straight to the done state, which
// moves the result to the output register once that register is free. A
// pop or peek passes through a read state first (the memory read). A search
// reads one entry per cycle through the read port, from the front, and
// stops at the first hit or after the last entry. The input reopens in the
// cycle after the result has moved to the output register, even while that
// result still waits to be taken downstream.
// ----------------------------------------------------------------------------
module bounded_deque_with_search
    import bdq_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // item_col[15:0], item_row[31:16]
    input  logic [KIND_W-1:0]    s_axis_tuser,  // kind[2:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_col[15:0], out_row[31:16], found[32], status[34:33],
    // occupancy[41:35], zero[47:42]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tuser   // out_valid[0]
);

    localparam int CW   = (COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH;
    localparam int IW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0]   LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + IW'(1);
    endfunction

    function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - IW'(1);
    endfunction

    function automatic logic [OCC_W-1:0] occ_of(input logic [CNTW-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[OCC_W-1:0];
    endfunction

    // ring memory, {row, col} per entry
    logic [2*CW-1:0] r_mem [DEPTH];
    logic [2*CW-1:0] r_rd_data;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_front, n_front;
    logic [IW-1:0]   r_back, n_back;
    logic [CNTW-1:0] r_count, n_count;
    t_kind           r_kind, n_kind;
    logic [CW-1:0]   r_col, n_col;
    logic [CW-1:0]   r_row, n_row;
    logic [IW-1:0]   r_scan_idx, n_scan_idx;
    logic [CNTW-1:0] r_scan_left, n_scan_left;
    t_result         r_res, n_res;
    logic            r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;
    logic            r_m_user;

    logic            w_accept;
    logic            w_out_free;
    logic            w_load;
    logic            w_hit;
    t_kind           w_in_kind;
    logic [CW-1:0]   w_in_col;
    logic [CW-1:0]   w_in_row;
    logic            w_wr_en;
    logic [IW-1:0]   w_wr_addr;
    logic [2*CW-1:0] w_wr_data;
    logic            w_rd_en;
    logic [IW-1:0]   w_rd_addr;
    logic [IW-1:0]   w_slot;
    logic [CNTW-1:0] w_count_dec;

    assign w_in_kind  = t_kind'(s_axis_tuser);
    assign w_in_col   = s_axis_tdata[CW-1:0];
    assign w_in_row   = s_axis_tdata[FIELD_W +: CW];
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_load     = (r_state == S_DONE) && w_out_free;
    assign w_hit      = (r_rd_data == {r_row, r_col});
    assign w_count_dec = r_count - CNTW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_in_kind) inside
                        KIND_POP_FRONT, KIND_POP_BACK, KIND_PEEK_FRONT, KIND_PEEK_BACK: begin
                            n_state = (r_count == '0) ? S_DONE : S_READ;
                        end
                        KIND_SEARCH: begin
                            n_state = (r_count == '0) ? S_DONE : S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (w_hit || (r_scan_left == '0)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        n_front     = r_front;
        n_back      = r_back;
        n_count     = r_count;
        n_kind      = r_kind;
        n_col       = r_col;
        n_row       = r_row;
        n_scan_idx  = r_scan_idx;
        n_scan_left = r_scan_left;
        n_res       = r_res;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_front;
        w_wr_data   = {w_in_row, w_in_col};
        w_rd_en     = 1'b0;
        w_rd_addr   = r_front;
        w_slot      = r_front;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind          = w_in_kind;
                    n_col           = w_in_col;
                    n_row           = w_in_row;
                    n_res           = '0;
                    n_res.status    = STAT_OK;
                    n_res.occupancy = occ_of(r_count);
                    unique case (w_in_kind) inside
                        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                            if (r_count == FULL_CNT) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                if (r_count == '0) begin
                                    w_slot = r_front;
                                    n_back = r_front;
                                end else if (w_in_kind == KIND_PUSH_FRONT) begin
                                    w_slot  = ring_prev(r_front);
                                    n_front = w_slot;
                                end else begin
                                    w_slot = ring_next(r_back);
                                    n_back = w_slot;
                                end
                                w_wr_en         = 1'b1;
                                w_wr_addr       = w_slot;
                                n_count         = r_count + CNTW'(1);
                                n_res.occupancy = occ_of(n_count);
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_BACK, KIND_PEEK_FRONT, KIND_PEEK_BACK: begin
                            if (r_count == '0) begin
                                n_res.status = STAT_EMPTY;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = ((w_in_kind == KIND_POP_FRONT) ||
                                             (w_in_kind == KIND_PEEK_FRONT)) ? r_front : r_back;
                            end
                        end
                        KIND_SEARCH: begin
                            if (r_count != '0) begin
                                w_rd_en     = 1'b1;
                                w_rd_addr   = r_front;
                                n_scan_idx  = ring_next(r_front);
                                n_scan_left = w_count_dec;
                            end
                        end
                        default: begin
                            n_count         = '0;
                            n_front         = '0;
                            n_back          = '0;
                            n_res.occupancy = '0;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res.out_col   = FIELD_W'(r_rd_data[CW-1:0]);
                n_res.out_row   = FIELD_W'(r_rd_data[2*CW-1:CW]);
                n_res.out_valid = 1'b1;
                if (r_kind == KIND_POP_FRONT) begin
                    n_count         = w_count_dec;
                    n_res.occupancy = occ_of(w_count_dec);
                    if (w_count_dec != '0) begin
                        n_front = ring_next(r_front);
                    end
                end else if (r_kind == KIND_POP_BACK) begin
                    n_count         = w_count_dec;
                    n_res.occupancy = occ_of(w_count_dec);
                    if (w_count_dec != '0) begin
                        n_back = ring_prev(r_back);
                    end
                end
            end
            S_SCAN: begin
                // compare the entry read last cycle, fetch the next on a miss
                if (w_hit) begin
                    n_res.found = 1'b1;
                end else if (r_scan_left != '0) begin
                    w_rd_en     = 1'b1;
                    w_rd_addr   = r_scan_idx;
                    n_scan_idx  = ring_next(r_scan_idx);
                    n_scan_left = r_scan_left - CNTW'(1);
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_front   <= '0;
            r_back    <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_col       <= n_col;
        r_row       <= n_row;
        r_scan_idx  <= n_scan_idx;
        r_scan_left <= n_scan_left;
        r_res       <= n_res;
        if (w_load) begin
            r_m_data <= {{M_PAD_W{1'b0}}, r_res.occupancy, r_res.status, r_res.found,
                         r_res.out_row, r_res.out_col};
            r_m_user <= r_res.out_valid;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

// ----- rtl/bdq_checker.sv -----
// ----------------------------------------------------------------------------
// Deque port checker
// Port-level assertions on the deque input and result streams, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_search_defines.svh"

module bdq_checker
    import bdq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);

    logic [STATUS_W-1:0] w_status;
    logic [OCC_W-1:0]    w_occ;
    logic                w_found;
    logic [31:0]         w_coord;

    assign w_coord  = m_axis_tdata[31:0];
    assign w_found  = m_axis_tdata[32];
    assign w_status = m_axis_tdata[34:33];
    assign w_occ    = m_axis_tdata[41:35];

    // stalled result holds
    `BDQ_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "result changed while stalled")

    // one operation at a time: no transfer right after a transfer
    `BDQ_ASSERT(a_one_at_a_time, (s_axis_tvalid && s_axis_tready |=> !s_axis_tready), "input taken while busy")

    `BDQ_ASSERT(a_entry_ok, (m_axis_tvalid && m_axis_tuser |-> (w_status == STAT_OK) && !w_found), "entry result with bad status or found")

    `BDQ_ASSERT(a_full_refused, (m_axis_tvalid && (w_status == STAT_FULL) |-> !m_axis_tuser && !w_found && (w_coord == '0)), "refused push carries data")

    `BDQ_ASSERT(a_empty_zero, (m_axis_tvalid && (w_status == STAT_EMPTY) |-> !m_axis_tuser && (w_coord == '0) && (w_occ == '0)), "empty pop or peek not clean")

endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/sv/bounded_deque_with_search_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded deque with search: testbench
// Sends push, pop, peek, search and clear operations over the input stream.
// A local deque model predicts one result per accepted operation. Each output
// transfer is checked field by field against the oldest prediction. Sender
// gaps and receiver stalls vary from phase to phase. One long receiver
// hold-off fills the pipeline and stalls the input.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_test;
    import bdq_pkg::*;

    localparam int DEPTH        = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 80;

    typedef struct {
        bit [FIELD_W-1:0] col;
        bit [FIELD_W-1:0] row;
        bit               valid;
        bit               found;
        t_status          status;
        bit [OCC_W-1:0]   occupancy;
    } t_coord_result;

    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} t_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // item_col[15:0], item_row[31:16]
    logic [KIND_W-1:0]    s_axis_tuser;   // kind[2:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // out_col[15:0], out_row[31:16], found[32], status[34:33], occupancy[41:35]
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;   // out_valid[0]

    // deque model state
    bit [2*FIELD_W-1:0] ring_mem [DEPTH];
    bit [5:0]           head_idx;
    bit [5:0]           tail_idx;
    int unsigned        held;

    t_coord_result      pending_results[$];
    bit [2*FIELD_W-1:0] coord_pool [8];
    int                 offer_gap_pct;
    int                 stall_pct;
    int                 hold_requests;
    int                 errors;

    bounded_deque_with_search u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Apply one operation to the model deque and return its result.
    function automatic t_coord_result apply_op(t_kind kind, bit [15:0] col,
                                               bit [15:0] row);
        t_coord_result res;
        bit [5:0]      slot;
        res = '{col: '0, row: '0, valid: 1'b0, found: 1'b0, status: STAT_OK,
                occupancy: '0};
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    if (held == 0) begin
                        tail_idx = head_idx;
                        slot     = head_idx;
                    end else if (kind == KIND_PUSH_FRONT) begin
                        head_idx = head_idx - 6'd1;
                        slot     = head_idx;
                    end else begin
                        tail_idx = tail_idx + 6'd1;
                        slot     = tail_idx;
                    end
                    ring_mem[slot] = {row, col};
                    held++;
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK, KIND_PEEK_FRONT, KIND_PEEK_BACK: begin
                if (held == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    slot = (kind == KIND_POP_FRONT || kind == KIND_PEEK_FRONT) ?
                           head_idx : tail_idx;
                    res.col   = ring_mem[slot][15:0];
                    res.row   = ring_mem[slot][31:16];
                    res.valid = 1'b1;
                    // indices stay put when the last entry leaves
                    if (kind == KIND_POP_FRONT) begin
                        held--;
                        if (held != 0) head_idx = head_idx + 6'd1;
                    end else if (kind == KIND_POP_BACK) begin
                        held--;
                        if (held != 0) tail_idx = tail_idx - 6'd1;
                    end
                end
            end
            KIND_SEARCH: begin
                slot = head_idx;
                for (int i = 0; i < held; i++) begin
                    if (ring_mem[slot] == {row, col}) res.found = 1'b1;
                    slot = slot + 6'd1;
                end
            end
            default: begin
                held     = 0;
                head_idx = '0;
                tail_idx = '0;
            end
        endcase
        res.occupancy = held[OCC_W-1:0];
        return res;
    endfunction

    function automatic bit [15:0] rand_half();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one operation, hold it until the transfer, then log its result.
    task automatic send_op(t_kind kind, bit [15:0] col, bit [15:0] row);
        if (offer_gap_pct > 0 && $urandom_range(99) < offer_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tuser  <= KIND_W'($urandom_range(7));
            do @(posedge i_clk); while ($urandom_range(99) < offer_gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row, col};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.insert(pending_results.size(), apply_op(kind, col, row));
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic check_field(string name, longint unsigned expv,
                               longint unsigned actv);
        if (expv != actv) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expv, actv);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_coord_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no operation outstanding: tdata 0x%0h",
                       m_axis_tdata);
                errors++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                check_field("out_col",   want.col,       m_axis_tdata[15:0]);
                check_field("out_row",   want.row,       m_axis_tdata[31:16]);
                check_field("found",     want.found,     m_axis_tdata[32]);
                check_field("status",    want.status,    m_axis_tdata[34:33]);
                check_field("occupancy", want.occupancy, m_axis_tdata[41:35]);
                check_field("out_valid", want.valid,     m_axis_tuser);
            end
        end
    end

    // Empty-queue accesses, one-entry pops, wrap of the front index,
    // search of the back entry, clear.
    task automatic test_edge_cases();
        offer_gap_pct = 0;
        stall_pct     = 0;
        send_op(KIND_POP_FRONT,  16'h0000, 16'h0000);
        send_op(KIND_POP_BACK,   16'hFFFF, 16'hFFFF);
        send_op(KIND_PEEK_FRONT, 16'h0000, 16'h0000);
        send_op(KIND_PEEK_BACK,  16'h0000, 16'h0000);
        send_op(KIND_SEARCH,     16'hFFFF, 16'hFFFF);
        send_op(KIND_PUSH_FRONT, 16'hFFFF, 16'hFFFF);
        send_op(KIND_POP_BACK,   16'h0000, 16'h0000);
        send_op(KIND_PUSH_BACK,  16'h0000, 16'h0000);
        send_op(KIND_PUSH_FRONT, 16'h1234, 16'hABCD);
        send_op(KIND_PUSH_BACK,  16'hFFFF, 16'h0000);
        send_op(KIND_PEEK_FRONT, 16'h0000, 16'h0000);
        send_op(KIND_PEEK_BACK,  16'h0000, 16'h0000);
        send_op(KIND_SEARCH,     16'hFFFF, 16'h0000);
        send_op(KIND_SEARCH,     16'h0000, 16'h0000);
        send_op(KIND_SEARCH,     16'hFFFF, 16'hFFFF);
        send_op(KIND_POP_FRONT,  16'h0000, 16'h0000);
        send_op(KIND_POP_BACK,   16'h0000, 16'h0000);
        send_op(KIND_POP_BACK,   16'h0000, 16'h0000);
        send_op(KIND_PUSH_BACK,  16'h5555, 16'hAAAA);
        send_op(KIND_CLEAR,      16'hFFFF, 16'hFFFF);
        send_op(KIND_PEEK_BACK,  16'h0000, 16'h0000);
        send_op(KIND_PUSH_FRONT, 16'h0000, 16'hFFFF);
        send_op(KIND_POP_FRONT,  16'h0000, 16'h0000);
    endtask

    // Fill to capacity, try both pushes on a full queue, search and drain a bit.
    task automatic test_full_queue();
        bit [15:0] last_col;
        bit [15:0] last_row;
        offer_gap_pct = 0;
        stall_pct     = 0;
        send_op(KIND_CLEAR, 16'h0000, 16'h0000);
        for (int i = 0; i < DEPTH; i++) begin
            last_col = rand_half();
            last_row = rand_half();
            send_op(i % 3 == 0 ? KIND_PUSH_FRONT : KIND_PUSH_BACK, last_col, last_row);
        end
        send_op(KIND_PUSH_FRONT, 16'hFFFF, 16'hFFFF);
        send_op(KIND_PUSH_BACK,  16'h0000, 16'h0000);
        send_op(KIND_SEARCH,     last_col, last_row);
        send_op(KIND_SEARCH,     ~last_col, last_row);
        send_op(KIND_PEEK_FRONT, 16'h0000, 16'h0000);
        send_op(KIND_PEEK_BACK,  16'h0000, 16'h0000);
        for (int i = 0; i < 8; i++)
            send_op(i[0] ? KIND_POP_BACK : KIND_POP_FRONT, 16'h0000, 16'h0000);
    endtask

    // Stop the receiver for a long stretch while operations keep coming.
    task automatic test_output_backpressure();
        offer_gap_pct = 0;
        stall_pct     = 0;
        hold_requests++;
        for (int i = 0; i < 30; i++) begin
            case (i % 5)
                0, 1:    send_op(KIND_PUSH_BACK, rand_half(), rand_half());
                2:       send_op(KIND_SEARCH, rand_half(), rand_half());
                3:       send_op(KIND_PEEK_FRONT, 16'h0000, 16'h0000);
                default: send_op(KIND_POP_FRONT, 16'h0000, 16'h0000);
            endcase
        end
    endtask

    // Random operations in grow, shrink and mixed stretches; coordinates
    // drawn mostly from a small pool so that searches hit.
    task automatic test_random_traffic(int gap_pct, int stall, int n_ops);
        t_mode     mode;
        int        left_in_mode;
        int        push_pct;
        int        clear_pct;
        int        pick;
        bit [15:0] col;
        bit [15:0] row;
        t_kind     kind;
        offer_gap_pct = gap_pct;
        stall_pct     = stall;
        left_in_mode  = 0;
        mode          = MODE_GROW;
        for (int n = 0; n < n_ops; n++) begin
            if (left_in_mode == 0) begin
                mode         = t_mode'($urandom_range(2));
                left_in_mode = $urandom_range(40, 140);
            end
            left_in_mode--;
            push_pct  = (mode == MODE_GROW) ? 62 : (mode == MODE_SHRINK) ? 18 : 40;
            clear_pct = (mode == MODE_MIXED) ? 3 : 0;
            if ($urandom_range(9) == 0)
                coord_pool[$urandom_range(7)] = {rand_half(), rand_half()};
            if ($urandom_range(99) < 65)
                {row, col} = coord_pool[$urandom_range(7)];
            else
                {row, col} = {rand_half(), rand_half()};
            pick = $urandom_range(99);
            if (pick < push_pct) begin
                kind = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
            end else if (pick >= 100 - clear_pct) begin
                kind = KIND_CLEAR;
            end else begin
                case ($urandom_range(7))
                    0, 1:    kind = KIND_POP_FRONT;
                    2, 3:    kind = KIND_POP_BACK;
                    4:       kind = KIND_PEEK_FRONT;
                    5:       kind = KIND_PEEK_BACK;
                    default: kind = KIND_SEARCH;
                endcase
            end
            send_op(kind, col, row);
        end
    endtask

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int guard;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        offer_gap_pct = 0;
        stall_pct     = 0;
        hold_requests = 0;
        errors        = 0;
        held          = 0;
        head_idx      = '0;
        tail_idx      = '0;
        for (int i = 0; i < 8; i++)
            coord_pool[i] = {rand_half(), rand_half()};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_cases();
        test_full_queue();
        test_output_backpressure();
        test_random_traffic(0, 0, 230);
        test_random_traffic(46, 0, 230);
        test_random_traffic(0, 46, 230);
        test_random_traffic(28, 28, 230);

        s_axis_tvalid <= 1'b0;
        stall_pct = 0;
        guard = 0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
